/* rtl/rtme_pkg.sv */
// Shared types and constants of the rendezvous tag match engine.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
package rtme_pkg;

  localparam int unsigned RingDepthDef = 512;
  localparam int unsigned MaxSlotsDef  = 8;
  localparam int unsigned QueueDepth   = 2;

  localparam int unsigned TagW  = 32;
  localparam int unsigned SizeW = 31;
  localparam int unsigned WordW = 64;
  localparam int unsigned SlotW = 3;
  localparam int unsigned KindW = 3;

  // item opcodes
  localparam logic OpAnnounce = 1'b0;
  localparam logic OpPost     = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_UNEXP = 3'd0,
    KIND_EXP   = 3'd1,
    KIND_READ  = 3'd2,
    KIND_ZERO  = 3'd3,
    KIND_FULL  = 3'd4,
    KIND_OVER  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_SKIP,
    ST_SKCHK
  } state_e;

  // one ring entry; the unexpected ring leaves slot unused
  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [SizeW-1:0] size;
    logic [WordW-1:0] address;
    logic [WordW-1:0] key;
    logic [WordW-1:0] handle;
    logic [SlotW-1:0] slot;
  } entry_t;

  typedef struct packed {
    logic   op;
    entry_t ent;
  } item_t;

  typedef struct packed {
    kind_e            kind;
    logic [WordW-1:0] receive_handle;
    logic [SlotW-1:0] matched_slot;
    logic [SizeW-1:0] matched_size;
    logic [WordW-1:0] local_address;
    logic [WordW-1:0] local_key;
    logic [WordW-1:0] remote_address;
    logic [WordW-1:0] remote_key;
    logic [WordW-1:0] sender_cookie;
  } result_t;

endpackage

/* rtl/rtme_item_if.sv */
// Input channel of the tag match engine: valid/ready plus item fields.
// Depends on rtme_pkg for field widths.
interface rtme_item_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic signed [rtme_pkg::TagW-1:0]  tag;
  logic [rtme_pkg::SizeW-1:0]        size;
  logic [rtme_pkg::WordW-1:0]        address;
  logic [rtme_pkg::WordW-1:0]        key;
  logic [rtme_pkg::WordW-1:0]        handle;
  logic [rtme_pkg::SlotW-1:0]        slot_index;

  modport source (output valid, op, tag, size, address, key, handle, slot_index,
                  input ready);
  modport sink (input valid, op, tag, size, address, key, handle, slot_index,
                output ready);
endinterface

/* rtl/rtme_result_if.sv */
// Result channel of the tag match engine: valid/ready plus descriptor fields.
// Depends on rtme_pkg for field widths.
interface rtme_result_if;
  logic                         valid;
  logic                         ready;
  logic [rtme_pkg::KindW-1:0]   kind;
  logic [rtme_pkg::WordW-1:0]   receive_handle;
  logic [rtme_pkg::SlotW-1:0]   matched_slot;
  logic [rtme_pkg::SizeW-1:0]   matched_size;
  logic [rtme_pkg::WordW-1:0]   local_address;
  logic [rtme_pkg::WordW-1:0]   local_key;
  logic [rtme_pkg::WordW-1:0]   remote_address;
  logic [rtme_pkg::WordW-1:0]   remote_key;
  logic [rtme_pkg::WordW-1:0]   sender_cookie;

  modport source (output valid, kind, receive_handle, matched_slot, matched_size,
                  local_address, local_key, remote_address, remote_key,
                  sender_cookie, input ready);
  modport sink (input valid, kind, receive_handle, matched_slot, matched_size,
                local_address, local_key, remote_address, remote_key,
                sender_cookie, output ready);
endinterface

/* rtl/rtme_front.sv */
// Front end: accepts input beats, folds the slot index and packs the item.
// Depends on rtme_pkg and rtme_item_if.
module rtme_front #(
  parameter int unsigned MaxSlots = rtme_pkg::MaxSlotsDef
) (
  rtme_item_if.sink       item_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output rtme_pkg::item_t q_data_o
);

  // slot index modulo MaxSlots by repeated subtraction (value below 8)
  function automatic logic [rtme_pkg::SlotW-1:0] fold_slot(
    input logic [rtme_pkg::SlotW-1:0] s);
    logic [6:0] v;
    v = 7'(s);
    for (int k = 0; k < 8; k++) begin
      if (v >= 7'(MaxSlots)) v = v - 7'(MaxSlots);
    end
    return v[rtme_pkg::SlotW-1:0];
  endfunction

  assign item_i.ready = q_ready_i;
  assign q_valid_o    = item_i.valid;

  // pack the beat for the queue
  always_comb begin
    q_data_o.op          = item_i.op;
    q_data_o.ent.tag     = item_i.tag;
    q_data_o.ent.size    = item_i.size;
    q_data_o.ent.address = item_i.address;
    q_data_o.ent.key     = item_i.key;
    q_data_o.ent.handle  = item_i.handle;
    q_data_o.ent.slot    = fold_slot(item_i.slot_index);
  end

endmodule

/* rtl/rtme_queue.sv */
// Short queue between front end and match sequencer.
// Depends on rtme_pkg for the item type and depth.
module rtme_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rtme_pkg::item_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rtme_pkg::item_t out_data_o
);

  localparam int unsigned AW = $clog2(rtme_pkg::QueueDepth);

  rtme_pkg::item_t buf_q [rtme_pkg::QueueDepth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]     cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != (AW+1)'(rtme_pkg::QueueDepth));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;
  assign out_data_o  = buf_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_data_i;
  end

endmodule

/* rtl/rtme_back.sv */
// Match sequencer: holds both rings, searches oldest-first, consumes or appends.
// Depends on rtme_pkg.
module rtme_back #(
  parameter int unsigned RingDepth = rtme_pkg::RingDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  rtme_pkg::item_t   q_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output rtme_pkg::result_t res_o
);

  localparam int unsigned IdxW = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int unsigned PtrW = $clog2(2 * RingDepth);
  localparam int unsigned UseW = PtrW + 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(2 * RingDepth - 1);

  function automatic logic [IdxW-1:0] idx_of(input logic [PtrW-1:0] p);
    return (p >= PtrW'(RingDepth)) ? IdxW'(p - PtrW'(RingDepth)) : IdxW'(p);
  endfunction

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  // ring storage
  rtme_pkg::entry_t umem [RingDepth];
  rtme_pkg::entry_t emem [RingDepth];
  logic             ulive [RingDepth];
  logic             elive [RingDepth];
  rtme_pkg::entry_t urd_q, erd_q;
  logic             ulv_q, elv_q;

  rtme_pkg::state_e  state_q, state_d;
  rtme_pkg::item_t   item_q;
  rtme_pkg::result_t res_q;
  logic [PtrW-1:0]   p_q, p_d, uh_q, uh_d, ut_q, ut_d, eh_q, eh_d, et_q, et_d;
  logic              out_valid_q, out_valid_d;

  logic              srch_exp, at_end, hit, full, rd_live;
  logic [PtrW-1:0]   s_head, s_tail, a_head, a_tail;
  logic [UseW-1:0]   used;
  rtme_pkg::entry_t  rd_ent;
  logic [IdxW-1:0]   rd_idx, a_idx;
  logic              pop, rd_en, app, clr, miss, set_head;
  logic              u_lwe, e_lwe, u_lval, e_lval;
  logic [IdxW-1:0]   u_lidx, e_lidx;
  rtme_pkg::result_t match_res, miss_res;

  // ring roles: an announcement searches expected and queues to unexpected
  always_comb begin
    srch_exp = (item_q.op == rtme_pkg::OpAnnounce);
    s_head   = srch_exp ? eh_q : uh_q;
    s_tail   = srch_exp ? et_q : ut_q;
    a_head   = srch_exp ? uh_q : eh_q;
    a_tail   = srch_exp ? ut_q : et_q;
    rd_ent   = srch_exp ? erd_q : urd_q;
    rd_live  = srch_exp ? elv_q : ulv_q;
    at_end   = (p_q == s_tail);
    hit      = rd_live && (rd_ent.tag == item_q.ent.tag);
    used     = (a_tail >= a_head) ? UseW'(a_tail - a_head)
             : UseW'({1'b0, a_tail} + UseW'(2 * RingDepth) - {1'b0, a_head});
    full     = (used >= UseW'(RingDepth));
    rd_idx   = idx_of(p_q);
    a_idx    = idx_of(a_tail);
  end

  // descriptors of a match and of a miss; sizes compared as announced vs capacity
  always_comb begin
    logic [rtme_pkg::SizeW-1:0] send, cap;
    send = srch_exp ? item_q.ent.size : rd_ent.size;
    cap  = srch_exp ? rd_ent.size : item_q.ent.size;
    if (send > cap)      match_res.kind = rtme_pkg::KIND_OVER;
    else if (send == '0) match_res.kind = rtme_pkg::KIND_ZERO;
    else                 match_res.kind = rtme_pkg::KIND_READ;
    match_res.receive_handle = srch_exp ? rd_ent.handle : item_q.ent.handle;
    match_res.matched_slot   = srch_exp ? rd_ent.slot : item_q.ent.slot;
    match_res.matched_size   = send;
    match_res.local_address  = srch_exp ? rd_ent.address : item_q.ent.address;
    match_res.local_key      = srch_exp ? rd_ent.key : item_q.ent.key;
    match_res.remote_address = srch_exp ? item_q.ent.address : rd_ent.address;
    match_res.remote_key     = srch_exp ? item_q.ent.key : rd_ent.key;
    match_res.sender_cookie  = srch_exp ? item_q.ent.handle : rd_ent.handle;

    miss_res      = '0;
    miss_res.kind = full ? rtme_pkg::KIND_FULL
                  : (srch_exp ? rtme_pkg::KIND_UNEXP : rtme_pkg::KIND_EXP);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtme_pkg::ST_IDLE:  if (q_valid_i && !out_valid_q) state_d = rtme_pkg::ST_SRCH;
      rtme_pkg::ST_SRCH:  state_d = at_end ? rtme_pkg::ST_IDLE : rtme_pkg::ST_CMP;
      rtme_pkg::ST_CMP:   state_d = hit ? rtme_pkg::ST_SKIP : rtme_pkg::ST_SRCH;
      rtme_pkg::ST_SKIP:  state_d = at_end ? rtme_pkg::ST_IDLE : rtme_pkg::ST_SKCHK;
      rtme_pkg::ST_SKCHK: state_d = rd_live ? rtme_pkg::ST_IDLE : rtme_pkg::ST_SKIP;
      default:            state_d = rtme_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop      = (state_q == rtme_pkg::ST_IDLE) && q_valid_i && !out_valid_q;
    rd_en    = ((state_q == rtme_pkg::ST_SRCH) || (state_q == rtme_pkg::ST_SKIP)) && !at_end;
    miss     = (state_q == rtme_pkg::ST_SRCH) && at_end;
    app      = miss && !full;
    clr      = (state_q == rtme_pkg::ST_CMP) && hit;
    set_head = ((state_q == rtme_pkg::ST_SKIP) && at_end)
            || ((state_q == rtme_pkg::ST_SKCHK) && rd_live);
    q_ready_o = (state_q == rtme_pkg::ST_IDLE) && !out_valid_q;

    // live bit write port per ring: set on append, clear on consume
    u_lwe  = (app && srch_exp) || (clr && !srch_exp);
    u_lidx = srch_exp ? a_idx : rd_idx;
    u_lval = srch_exp;
    e_lwe  = (app && !srch_exp) || (clr && srch_exp);
    e_lidx = srch_exp ? rd_idx : a_idx;
    e_lval = !srch_exp;
  end

  // pointer and result-valid next values
  always_comb begin
    p_d  = p_q;
    uh_d = uh_q;
    ut_d = ut_q;
    eh_d = eh_q;
    et_d = et_q;
    if (pop) p_d = (q_data_i.op == rtme_pkg::OpAnnounce) ? eh_q : uh_q;
    if (state_q == rtme_pkg::ST_CMP) p_d = hit ? s_head : ptr_next(p_q);
    if ((state_q == rtme_pkg::ST_SKCHK) && !rd_live) p_d = ptr_next(p_q);
    if (app) begin
      if (srch_exp) ut_d = ptr_next(ut_q);
      else          et_d = ptr_next(et_q);
    end
    if (set_head) begin
      if (srch_exp) eh_d = p_q;
      else          uh_d = p_q;
    end
    out_valid_d = miss || clr || (out_valid_q && !res_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtme_pkg::ST_IDLE;
      p_q         <= '0;
      uh_q        <= '0;
      ut_q        <= '0;
      eh_q        <= '0;
      et_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      uh_q        <= uh_d;
      ut_q        <= ut_d;
      eh_q        <= eh_d;
      et_q        <= et_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop)  item_q <= q_data_i;
    if (miss) res_q  <= miss_res;
    if (clr)  res_q  <= match_res;
  end

  // unexpected ring memory, registered read
  always_ff @(posedge clk_i) begin
    if (app && srch_exp) umem[a_idx] <= item_q.ent;
    if (u_lwe) ulive[u_lidx] <= u_lval;
    if (rd_en) begin
      urd_q <= umem[rd_idx];
      ulv_q <= ulive[rd_idx];
    end
  end

  // expected ring memory, registered read
  always_ff @(posedge clk_i) begin
    if (app && !srch_exp) emem[a_idx] <= item_q.ent;
    if (e_lwe) elive[e_lidx] <= e_lval;
    if (rd_en) begin
      erd_q <= emem[rd_idx];
      elv_q <= elive[rd_idx];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/rendezvous_tag_match_engine.sv */
// Rendezvous tag match engine: each input beat is a send announcement or a posted
// receive slot, and it yields exactly one result beat. A two-beat queue takes
// beats while the sequencer works or while a result beat waits to be taken.
// The sequencer compares ring entries one at a time, oldest first: a registered
// memory read (SRCH), then a compare (CMP). An item leaves the queue, then each
// entry is read and compared up to the hit or the tail; on a miss the tail is
// seen in SRCH and the result is registered. After a hit the head is rechecked:
// each consumed entry or hole at the front is read (SKIP) and checked (SKCHK)
// until the first live entry or the tail is reached. The next item leaves the
// queue only once the previous result beat has been taken, so a stalled result
// side stalls the input after two beats.
// No clearing pass is needed after reset: only entries between head and tail
// are ever read.
// Depends on rtme_pkg, rtme_item_if, rtme_result_if, rtme_front, rtme_queue
// and rtme_back.
module rendezvous_tag_match_engine #(
  parameter int unsigned RING_DEPTH = rtme_pkg::RingDepthDef,
  parameter int unsigned MAX_SLOTS  = rtme_pkg::MaxSlotsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rtme_item_if.sink       item_i,
  rtme_result_if.source   result_o
);

  logic              fq_valid, fq_ready, bq_valid, bq_ready;
  rtme_pkg::item_t   fq_data, bq_data;
  rtme_pkg::result_t res;

  rtme_front #(.MaxSlots(MAX_SLOTS)) u_front (
    .item_i    (item_i),
    .q_valid_o (fq_valid),
    .q_ready_i (fq_ready),
    .q_data_o  (fq_data)
  );

  rtme_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_data_i   (fq_data),
    .out_valid_o (bq_valid),
    .out_ready_i (bq_ready),
    .out_data_o  (bq_data)
  );

  rtme_back #(.RingDepth(RING_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (bq_valid),
    .q_ready_o   (bq_ready),
    .q_data_i    (bq_data),
    .res_valid_o (result_o.valid),
    .res_ready_i (result_o.ready),
    .res_o       (res)
  );

  // result beat fields
  assign result_o.kind           = res.kind;
  assign result_o.receive_handle = res.receive_handle;
  assign result_o.matched_slot   = res.matched_slot;
  assign result_o.matched_size   = res.matched_size;
  assign result_o.local_address  = res.local_address;
  assign result_o.local_key      = res.local_key;
  assign result_o.remote_address = res.remote_address;
  assign result_o.remote_key     = res.remote_key;
  assign result_o.sender_cookie  = res.sender_cookie;

endmodule

/* tb/rtme_tb_pkg.sv */
`timescale 1ns / 1ps
// Testbench types for the rendezvous tag match engine: one input item.
// Depends on rtme_pkg for field widths.
package rtme_tb_pkg;
  import rtme_pkg::*;

  typedef struct packed {
    logic                    op;
    logic signed [TagW-1:0]  tag;
    logic [SizeW-1:0]        size;
    logic [WordW-1:0]        address;
    logic [WordW-1:0]        key;
    logic [WordW-1:0]        handle;
    logic [SlotW-1:0]        slot_index;
  } req_t;
endpackage

/* tb/rendezvous_tag_match_engine_tb.sv */
`timescale 1ns / 1ps
// Testbench of rendezvous_tag_match_engine: directed table, ring overflow, then random traffic,
// checked against an in-bench ring model. Depends on rtme_pkg, rtme_tb_pkg, the ifs and the engine.
module rendezvous_tag_match_engine_tb;
  import rtme_pkg::*;
  import rtme_tb_pkg::*;

  localparam int unsigned Depth = RingDepthDef;
  localparam int unsigned PtrMod = 2 * Depth;
  localparam int unsigned NumRandom = 330;
  localparam longint CycleLimit = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rtme_item_if   item_if ();
  rtme_result_if res_if ();

  rendezvous_tag_match_engine uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if.sink),
    .result_o(res_if.source)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: two rings of entries with live flags
  entry_t      unexp_ring [Depth];
  entry_t      exp_ring   [Depth];
  bit          unexp_live [Depth];
  bit          exp_live   [Depth];
  int unsigned unexp_hd, unexp_tl, exp_hd, exp_tl;

  result_t     pending_results [$];
  int          fail_count = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          kind_seen [6];
  longint      cycle_cnt = 0;
  bit          long_hold = 1'b0;

  function automatic int find_tag(bit from_exp, logic [TagW-1:0] tag);
    int unsigned p;
    p = from_exp ? exp_hd : unexp_hd;
    while (p != (from_exp ? exp_tl : unexp_tl)) begin
      if (from_exp ? (exp_live[p % Depth] && exp_ring[p % Depth].tag == tag)
                   : (unexp_live[p % Depth] && unexp_ring[p % Depth].tag == tag))
        return p % Depth;
      p = (p + 1) % PtrMod;
    end
    return -1;
  endfunction

  function automatic result_t fill_match(logic [SizeW-1:0] snd, logic [SizeW-1:0] cap,
                                         entry_t rcv, entry_t snt);
    result_t r;
    r.kind = (snd > cap) ? KIND_OVER : (snd == 0) ? KIND_ZERO : KIND_READ;
    r.receive_handle = rcv.handle;
    r.matched_slot   = rcv.slot;
    r.matched_size   = snd;
    r.local_address  = rcv.address;
    r.local_key      = rcv.key;
    r.remote_address = snt.address;
    r.remote_key     = snt.key;
    r.sender_cookie  = snt.handle;
    return r;
  endfunction

  // compute the result of one accepted item and update the rings
  function automatic result_t match_item(req_t q);
    result_t r;
    entry_t  e;
    int      hit;
    r = '0;
    e.tag = q.tag; e.size = q.size; e.address = q.address;
    e.key = q.key; e.handle = q.handle; e.slot = SlotW'(q.slot_index % MaxSlotsDef);
    if (q.op == OpAnnounce) begin
      hit = find_tag(1'b1, q.tag);
      if (hit >= 0) begin
        r = fill_match(q.size, exp_ring[hit].size, exp_ring[hit], e);
        exp_live[hit] = 1'b0;
        while (exp_hd != exp_tl && !exp_live[exp_hd % Depth]) exp_hd = (exp_hd + 1) % PtrMod;
      end else if ((unexp_tl + PtrMod - unexp_hd) % PtrMod >= Depth) begin
        r.kind = KIND_FULL;
      end else begin
        unexp_ring[unexp_tl % Depth] = e;
        unexp_live[unexp_tl % Depth] = 1'b1;
        unexp_tl = (unexp_tl + 1) % PtrMod;
        r.kind = KIND_UNEXP;
      end
    end else begin
      hit = find_tag(1'b0, q.tag);
      if (hit >= 0) begin
        r = fill_match(unexp_ring[hit].size, q.size, e, unexp_ring[hit]);
        unexp_live[hit] = 1'b0;
        while (unexp_hd != unexp_tl && !unexp_live[unexp_hd % Depth])
          unexp_hd = (unexp_hd + 1) % PtrMod;
      end else if ((exp_tl + PtrMod - exp_hd) % PtrMod >= Depth) begin
        r.kind = KIND_FULL;
      end else begin
        exp_ring[exp_tl % Depth] = e;
        exp_live[exp_tl % Depth] = 1'b1;
        exp_tl = (exp_tl + 1) % PtrMod;
        r.kind = KIND_EXP;
      end
    end
    return r;
  endfunction

  // directed table; want_kind is checked where it is obvious, else 7 = predictor only
  typedef struct {
    req_t     q;
    int       want_kind;
  } step_t;
  step_t steps [$];

  function automatic req_t mk(logic op, logic [31:0] tag, logic [SizeW-1:0] size,
                              logic [63:0] a, logic [63:0] k, logic [63:0] h,
                              logic [2:0] s);
    req_t q;
    q.op = op; q.tag = tag; q.size = size; q.address = a;
    q.key = k; q.handle = h; q.slot_index = s;
    return q;
  endfunction

  function automatic req_t rand_req(bit biased);
    req_t q;
    q.op = 1'($urandom_range(0, 1));
    q.tag = biased ? 32'($urandom_range(0, 15)) - 32'sd8 : $urandom;
    case ($urandom_range(0, 5))
      0: q.size = '0;
      1: q.size = '1;
      2: q.size = SizeW'($urandom);
      default: q.size = SizeW'($urandom_range(0, 4096));
    endcase
    q.address = {$urandom, $urandom};
    q.key = {$urandom, $urandom};
    q.handle = {$urandom, $urandom};
    q.slot_index = SlotW'($urandom_range(0, 7));
    return q;
  endfunction

  // valid stays high into the next beat when no idle cycles are drawn
  task automatic send(req_t q);
    int gap;
    gap = long_hold ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.op <= q.op; item_if.tag <= q.tag; item_if.size <= q.size;
    item_if.address <= q.address; item_if.key <= q.key;
    item_if.handle <= q.handle; item_if.slot_index <= q.slot_index;
    do @(posedge clk_i); while (!item_if.ready);
    pending_results.push_back(match_item(q));
    beats_in++;
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // result side: random stall per beat, one long hold-off on request
  initial begin
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        res_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // result checker, sampled at the accepting edge
  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && res_if.valid && res_if.ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        w = pending_results.pop_front();
        if (res_if.kind < 6) kind_seen[res_if.kind]++;
        if (res_if.kind != w.kind) begin
          $error("kind exp %0d got %0d", w.kind, res_if.kind); fail_count++;
        end
        if (res_if.receive_handle != w.receive_handle) begin
          $error("receive_handle exp %h got %h", w.receive_handle, res_if.receive_handle);
          fail_count++;
        end
        if (res_if.matched_slot != w.matched_slot) begin
          $error("matched_slot exp %0d got %0d", w.matched_slot, res_if.matched_slot);
          fail_count++;
        end
        if (res_if.matched_size != w.matched_size) begin
          $error("matched_size exp %h got %h", w.matched_size, res_if.matched_size);
          fail_count++;
        end
        if (res_if.local_address != w.local_address) begin
          $error("local_address exp %h got %h", w.local_address, res_if.local_address);
          fail_count++;
        end
        if (res_if.local_key != w.local_key) begin
          $error("local_key exp %h got %h", w.local_key, res_if.local_key); fail_count++;
        end
        if (res_if.remote_address != w.remote_address) begin
          $error("remote_address exp %h got %h", w.remote_address, res_if.remote_address);
          fail_count++;
        end
        if (res_if.remote_key != w.remote_key) begin
          $error("remote_key exp %h got %h", w.remote_key, res_if.remote_key); fail_count++;
        end
        if (res_if.sender_cookie != w.sender_cookie) begin
          $error("sender_cookie exp %h got %h", w.sender_cookie, res_if.sender_cookie);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    req_t q;
    int   want;
    item_if.valid = 1'b0;
    item_if.op = OpAnnounce;
    item_if.tag = '0; item_if.size = '0; item_if.address = '0;
    item_if.key = '0; item_if.handle = '0; item_if.slot_index = '0;
    for (int i = 0; i < Depth; i++) begin
      unexp_live[i] = 1'b0; exp_live[i] = 1'b0;
    end
    unexp_hd = 0; unexp_tl = 0; exp_hd = 0; exp_tl = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows: queueing, all match kinds, extremes, out-of-order consumption
    steps.push_back('{mk(OpAnnounce, 32'h8000_0000, '1, '1, '1, '1, 0), KIND_UNEXP});
    steps.push_back('{mk(OpPost, 32'h7fff_ffff, '0, '0, '0, '0, 7), KIND_EXP});
    steps.push_back('{mk(OpPost, 32'h8000_0000, '1, 64'h1, 64'h2, 64'h3, 7), KIND_READ});
    steps.push_back('{mk(OpAnnounce, 32'h7fff_ffff, 1, 64'h5, 64'h6, 64'h7, 0), KIND_OVER});
    steps.push_back('{mk(OpPost, 32'h0, 100, 64'ha, 64'hb, 64'hc, 3), KIND_EXP});
    steps.push_back('{mk(OpAnnounce, 32'h0, 0, 64'hd, 64'he, 64'hf, 0), KIND_ZERO});
    steps.push_back('{mk(OpPost, 32'hffff_ffff, 50, 64'h11, 64'h12, 64'h13, 1), KIND_EXP});
    steps.push_back('{mk(OpPost, 32'h1, 50, 64'h21, 64'h22, 64'h23, 2), KIND_EXP});
    steps.push_back('{mk(OpPost, 32'hffff_ffff, 50, 64'h31, 64'h32, 64'h33, 4), KIND_EXP});
    steps.push_back('{mk(OpAnnounce, 32'h1, 50, 64'h41, 64'h42, 64'h43, 5), 7});
    steps.push_back('{mk(OpAnnounce, 32'hffff_ffff, 49, 64'h51, 64'h52, 64'h53, 6), 7});
    steps.push_back('{mk(OpAnnounce, 32'hffff_ffff, 51, 64'h61, 64'h62, 64'h63, 6), 7});
    steps.push_back('{mk(OpAnnounce, 32'h5, 7, 64'h71, 64'h72, 64'h73, 0), KIND_UNEXP});
    steps.push_back('{mk(OpAnnounce, 32'h5, 8, 64'h81, 64'h82, 64'h83, 0), KIND_UNEXP});
    steps.push_back('{mk(OpPost, 32'h5, 8, 64'h91, 64'h92, 64'h93, 6), 7});
    steps.push_back('{mk(OpPost, 32'h5, 7, 64'ha1, 64'ha2, 64'ha3, 5), 7});
    foreach (steps[i]) begin
      want = steps[i].want_kind;
      send(steps[i].q);
      if (want != 7 && pending_results[$].kind != kind_e'(want)) begin
        $error("directed row %0d: kind exp %0d, model %0d", i, want,
               pending_results[$].kind);
        fail_count++;
      end
    end
    drain();

    // fill the unexpected ring to overflow while results are held off
    long_hold = 1'b1;
    for (int i = 0; i < Depth + 3; i++) begin
      q = rand_req(1'b0);
      q.op = OpAnnounce;
      q.tag = 32'h4000_0000 + i;
      send(q);
    end
    // and empty part of it again, youngest tags first to leave holes
    for (int i = 40; i >= 0; i--) begin
      q = rand_req(1'b0);
      q.op = OpPost;
      q.tag = 32'h4000_0000 + i * 3;
      send(q);
    end
    drain();

    // random traffic: mostly small tag set so matches are frequent
    for (int n = 0; n < NumRandom; n++) begin
      send(rand_req($urandom_range(0, 9) != 0));
      if (n == NumRandom / 2) drain();
    end
    drain();
    repeat (200) @(posedge clk_i);

    $display("Items sent %0d, results checked %0d", beats_in, beats_out);
    $display("Kinds seen: unexp %0d exp %0d read %0d zero %0d full %0d over %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5]);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
